[design/amld_pkg.sv]
`default_nettype none

package amld_pkg;

    // Map geometry
    localparam int unsigned MAP_TEXELS = 4096;
    localparam int unsigned ROW_TEXELS = 64;
    localparam int unsigned POS_W      = 13;
    localparam int unsigned INDEX_W    = 12;
    localparam int unsigned VALUE_W    = 8;
    localparam int unsigned LEN_W      = 7;

    // Writes one source word can cause, and the width of their count
    localparam int unsigned MAX_WRITES = 4;
    localparam int unsigned CNT_W      = 3;

    // Decode modes held in the configuration register
    typedef enum logic [1:0] {
        MODE_RLE     = 2'd0,
        MODE_RAW     = 2'd1,
        MODE_NIB     = 2'd2,
        MODE_NIB_FIX = 2'd3
    } t_mode;

    // One texel write: first index, value, run length
    typedef struct packed {
        logic [INDEX_W-1:0] index;
        logic [VALUE_W-1:0] value;
        logic [LEN_W-1:0]   len;
    } t_write;

    // All writes caused by one source word
    typedef struct packed {
        t_write [MAX_WRITES-1:0] writes;
        logic   [CNT_W-1:0]      count;
    } t_job;

    // Expand a nibble to an 8-bit value (times 17)
    function automatic logic [VALUE_W-1:0] expand_nibble(input logic [3:0] nib);
        expand_nibble = {nib, nib};
    endfunction

endpackage

`default_nettype wire

[design/amld_in_if.sv]
`default_nettype none

interface amld_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] src_byte;
    logic       last_byte;

    modport source (output valid, output src_byte, output last_byte, input ready);
    modport sink   (input valid, input src_byte, input last_byte, output ready);
endinterface

`default_nettype wire

[design/amld_out_if.sv]
`default_nettype none

interface amld_out_if;
    logic        valid;
    logic        ready;
    logic [11:0] texel_index;
    logic [7:0]  texel_value;
    logic [6:0]  run_length;
    logic        last_result;

    modport source (output valid, output texel_index, output texel_value,
                    output run_length, output last_result, input ready);
    modport sink   (input valid, input texel_index, input texel_value,
                    input run_length, input last_result, output ready);
endinterface

`default_nettype wire

[design/amld_front.sv]
`default_nettype none

module amld_front (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_cfg_we,
    input  wire  [1:0]        i_cfg_wdata,
    amld_in_if.sink           i_src,
    input  wire               i_queue_full,
    output logic              o_push,
    output amld_pkg::t_job    o_job
);

    typedef enum logic [1:0] {
        PH_CODE = 2'd0,
        PH_FILL = 2'd1,
        PH_LIT  = 2'd2
    } t_phase;

    localparam logic [amld_pkg::POS_W-1:0] MAP_END = amld_pkg::POS_W'(amld_pkg::MAP_TEXELS);
    localparam logic [5:0] COL_LAST = 6'(amld_pkg::ROW_TEXELS - 1);
    localparam logic [5:0] COL_NEXT = 6'(amld_pkg::ROW_TEXELS - 2);

    amld_pkg::t_mode              r_mode;
    logic [amld_pkg::POS_W-1:0]   r_pos,   n_pos;
    t_phase                       r_phase, n_phase;
    logic [amld_pkg::LEN_W-1:0]   r_rem,   n_rem;

    amld_pkg::t_job               job;
    logic                         accept;

    assign i_src.ready = !i_queue_full;
    assign accept      = i_src.valid && !i_queue_full;

    // Classify the word and build its write list
    always_comb begin
        logic [amld_pkg::POS_W-1:0]   room;
        logic [amld_pkg::LEN_W-1:0]   len;
        logic [amld_pkg::CNT_W-1:0]   cnt;
        logic [amld_pkg::POS_W-1:0]   nib_pos;
        logic [amld_pkg::POS_W-1:0]   pos2;
        logic [3:0]                   nib;
        logic [amld_pkg::VALUE_W-1:0] val;
        logic [amld_pkg::LEN_W-1:0]   fix_len;
        logic [7:0]                   b;

        b       = i_src.src_byte;
        room    = MAP_END - r_pos;
        len     = '0;
        cnt     = '0;
        nib_pos = '0;
        nib     = '0;
        val     = '0;
        fix_len = '0;
        pos2    = r_pos + amld_pkg::POS_W'(2);
        job     = '0;
        n_pos   = r_pos;
        n_phase = r_phase;
        n_rem   = r_rem;

        case (r_mode)
            amld_pkg::MODE_RLE: begin
                case (r_phase)
                    PH_FILL: begin
                        len = ({6'd0, r_rem} > room) ? room[amld_pkg::LEN_W-1:0] : r_rem;
                        if (len != '0) begin
                            job.writes[0] = '{index: r_pos[amld_pkg::INDEX_W-1:0],
                                              value: b, len: len};
                            cnt = amld_pkg::CNT_W'(1);
                        end
                        n_pos   = r_pos + {6'd0, len};
                        n_rem   = '0;
                        n_phase = PH_CODE;
                    end
                    PH_LIT: begin
                        if (room != '0) begin
                            job.writes[0] = '{index: r_pos[amld_pkg::INDEX_W-1:0],
                                              value: b, len: amld_pkg::LEN_W'(1)};
                            cnt   = amld_pkg::CNT_W'(1);
                            n_pos = r_pos + amld_pkg::POS_W'(1);
                        end
                        n_rem = r_rem - amld_pkg::LEN_W'(1);
                        if (n_rem == '0) begin
                            n_phase = PH_CODE;
                        end
                    end
                    default: begin
                        n_rem = b[6:0];
                        if (b[7]) begin
                            n_phase = PH_FILL;
                        end else if (b[6:0] != '0) begin
                            n_phase = PH_LIT;
                        end else begin
                            n_phase = PH_CODE;
                        end
                    end
                endcase
            end
            amld_pkg::MODE_RAW: begin
                if (r_pos < MAP_END) begin
                    job.writes[0] = '{index: r_pos[amld_pkg::INDEX_W-1:0],
                                      value: b, len: amld_pkg::LEN_W'(1)};
                    cnt   = amld_pkg::CNT_W'(1);
                    n_pos = r_pos + amld_pkg::POS_W'(1);
                end
            end
            amld_pkg::MODE_NIB: begin
                for (int k = 0; k < 2; k++) begin
                    nib_pos = r_pos + amld_pkg::POS_W'(k);
                    nib     = (k == 0) ? b[3:0] : b[7:4];
                    if (nib_pos < MAP_END) begin
                        job.writes[cnt[1:0]] = '{index: nib_pos[amld_pkg::INDEX_W-1:0],
                                                 value: amld_pkg::expand_nibble(nib),
                                                 len:   amld_pkg::LEN_W'(1)};
                        cnt = cnt + amld_pkg::CNT_W'(1);
                    end
                end
                n_pos = (pos2 > MAP_END) ? MAP_END : pos2;
            end
            default: begin
                // Skip last column and row; widen column 62, repeat row 62
                for (int k = 0; k < 2; k++) begin
                    nib_pos = r_pos + amld_pkg::POS_W'(k);
                    nib     = (k == 0) ? b[3:0] : b[7:4];
                    val     = amld_pkg::expand_nibble(nib);
                    fix_len = (nib_pos[5:0] == COL_NEXT) ? amld_pkg::LEN_W'(2)
                                                         : amld_pkg::LEN_W'(1);
                    if (nib_pos < MAP_END && nib_pos[5:0] != COL_LAST
                            && nib_pos[11:6] != COL_LAST) begin
                        job.writes[cnt[1:0]] = '{index: nib_pos[amld_pkg::INDEX_W-1:0],
                                                 value: val, len: fix_len};
                        cnt = cnt + amld_pkg::CNT_W'(1);
                        if (nib_pos[11:6] == COL_NEXT) begin
                            job.writes[cnt[1:0]] =
                                '{index: nib_pos[amld_pkg::INDEX_W-1:0]
                                         + amld_pkg::INDEX_W'(amld_pkg::ROW_TEXELS),
                                  value: val, len: fix_len};
                            cnt = cnt + amld_pkg::CNT_W'(1);
                        end
                    end
                end
                n_pos = (pos2 > MAP_END) ? MAP_END : pos2;
            end
        endcase

        job.count = cnt;
    end

    assign o_job  = job;
    assign o_push = accept && (job.count != '0);

    // Hold mode and decode state; clear state after the final word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= amld_pkg::MODE_RLE;
            r_pos   <= '0;
            r_phase <= PH_CODE;
            r_rem   <= '0;
        end else begin
            if (i_cfg_we) begin
                r_mode <= amld_pkg::t_mode'(i_cfg_wdata);
            end
            if (accept) begin
                if (i_src.last_byte) begin
                    r_pos   <= '0;
                    r_phase <= PH_CODE;
                    r_rem   <= '0;
                end else begin
                    r_pos   <= n_pos;
                    r_phase <= n_phase;
                    r_rem   <= n_rem;
                end
            end
        end
    end

endmodule

`default_nettype wire

[design/amld_job_queue.sv]
`default_nettype none

module amld_job_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_push,
    input  amld_pkg::t_job   i_job,
    output logic             o_full,
    input  wire              i_pop,
    output logic             o_head_valid,
    output amld_pkg::t_job   o_head
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    amld_pkg::t_job     r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;

    assign o_full       = (r_count == CNT_FULL);
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_mem[r_rd_ptr];

    // Store pushed jobs
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

[design/amld_back.sv]
`default_nettype none

module amld_back (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_head_valid,
    input  amld_pkg::t_job   i_head,
    output logic             o_pop,
    amld_out_if.source       o_res
);

    logic [1:0]        r_idx;
    logic              r_valid;
    amld_pkg::t_write  r_write;
    logic              r_last;

    logic              load;
    logic              at_end;

    assign load   = i_head_valid && (!r_valid || o_res.ready);
    assign at_end = ({1'b0, r_idx} == (i_head.count - amld_pkg::CNT_W'(1)));
    assign o_pop  = load && at_end;

    assign o_res.valid       = r_valid;
    assign o_res.texel_index = r_write.index;
    assign o_res.texel_value = r_write.value;
    assign o_res.run_length  = r_write.len;
    assign o_res.last_result = r_last;

    // Step through the head job, one write per word taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx   <= at_end ? 2'd0 : r_idx + 2'd1;
            end else if (o_res.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Load output word
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_write <= i_head.writes[r_idx];
            r_last  <= at_end;
        end
    end

endmodule

`default_nettype wire

[design/alpha_map_layer_decoder.sv]
// Alpha map layer decoder: turns the encoded bytes of one 64x64 alpha layer
// into texel writes (first index, value, run length).
// Channels: i_src carries source words (src_byte, last_byte); o_res carries
// write words (texel_index, texel_value, run_length, last_result), both with
// valid/ready. i_cfg_we/i_cfg_wdata set decode_mode; the user sets it only
// while the block is idle; the block itself does not enforce this. Each
// write list is registered in the job queue, then loaded into the output
// word. The back end issues one write per cycle while the receiver is ready.
// A source word causes at most one write in run-length and raw modes, up to
// two in 4-bit modes (up to four at the row-62 fix-up). The front end decodes
// each word combinationally and parks its write list in a QUEUE_DEPTH-entry
// job queue, so it keeps accepting as the back end drains. When the receiver
// stalls, the output word holds, the queue fills and then i_src.ready drops.
// Reset (synchronous, active low) clears position, run-length phase and
// count, empties the queue and sets decode_mode to run-length. A word with
// last_byte set returns the decode state to its reset value after decoding.
`default_nettype none

module alpha_map_layer_decoder #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire  [1:0]  i_cfg_wdata,
    amld_in_if.sink     i_src,
    amld_out_if.source  o_res
);

    logic            push;
    logic            pop;
    logic            full;
    logic            head_valid;
    amld_pkg::t_job  job;
    amld_pkg::t_job  head;

    amld_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_src        (i_src),
        .i_queue_full (full),
        .o_push       (push),
        .o_job        (job)
    );

    amld_job_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_job        (job),
        .o_full       (full),
        .i_pop        (pop),
        .o_head_valid (head_valid),
        .o_head       (head)
    );

    amld_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_pop        (pop),
        .o_res        (o_res)
    );

endmodule

`default_nettype wire
